// ----- hw/rtl/rpg_pkg.sv -----
package rpg_pkg;

    // Raster timing, in color clocks.
    localparam logic [7:0] LINE_CLOCKS     = 8'd228;
    localparam logic [7:0] LAST_COLUMN     = 8'd227;
    localparam logic [7:0] BLANK_CLOCKS    = 8'd68;
    localparam logic [8:0] VISIBLE_COLUMNS = 9'd160;

    // Stream word widths.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 64;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SHOW_PF = 2'd0;
    localparam logic [1:0] CFG_SHOW_P0 = 2'd1;
    localparam logic [1:0] CFG_SHOW_P1 = 2'd2;

    // Bus write map.
    localparam logic [5:0] ADDR_VSYNC  = 6'h00;
    localparam logic [5:0] ADDR_VBLANK = 6'h01;
    localparam logic [5:0] ADDR_WSYNC  = 6'h02;
    localparam logic [5:0] ADDR_NUSIZ0 = 6'h04;
    localparam logic [5:0] ADDR_NUSIZ1 = 6'h05;
    localparam logic [5:0] ADDR_COLUP0 = 6'h06;
    localparam logic [5:0] ADDR_COLUP1 = 6'h07;
    localparam logic [5:0] ADDR_COLUPF = 6'h08;
    localparam logic [5:0] ADDR_COLUBK = 6'h09;
    localparam logic [5:0] ADDR_CTRLPF = 6'h0A;
    localparam logic [5:0] ADDR_PF0    = 6'h0D;
    localparam logic [5:0] ADDR_PF1    = 6'h0E;
    localparam logic [5:0] ADDR_PF2    = 6'h0F;
    localparam logic [5:0] ADDR_RESP0  = 6'h10;
    localparam logic [5:0] ADDR_RESP1  = 6'h11;
    localparam logic [5:0] ADDR_GRP0   = 6'h1B;
    localparam logic [5:0] ADDR_GRP1   = 6'h1C;
    localparam logic [5:0] ADDR_HMP0   = 6'h20;
    localparam logic [5:0] ADDR_HMP1   = 6'h21;

    // Shape of a player for one size mode. All copy spans are powers of two,
    // so the offset within a copy is a mask and the pixel scale a shift.
    typedef struct packed {
        logic [2:0] span_sh;
        logic [1:0] scale_sh;
        logic [7:0] extent;
    } sprite_shape_t;

    function automatic sprite_shape_t sprite_shape(input logic [2:0] mode);
        sprite_shape_t s;
        unique case (mode)
            3'd0:    s = '{span_sh: 3'd3, scale_sh: 2'd0, extent: 8'd8};
            3'd1:    s = '{span_sh: 3'd4, scale_sh: 2'd0, extent: 8'd32};
            3'd2:    s = '{span_sh: 3'd5, scale_sh: 2'd0, extent: 8'd64};
            3'd3:    s = '{span_sh: 3'd4, scale_sh: 2'd0, extent: 8'd48};
            3'd4:    s = '{span_sh: 3'd6, scale_sh: 2'd0, extent: 8'd128};
            3'd5:    s = '{span_sh: 3'd4, scale_sh: 2'd1, extent: 8'd16};
            3'd6:    s = '{span_sh: 3'd5, scale_sh: 2'd0, extent: 8'd96};
            default: s = '{span_sh: 3'd5, scale_sh: 2'd2, extent: 8'd32};
        endcase
        return s;
    endfunction

endpackage

// ----- hw/rtl/rpg_sprite.sv -----
module rpg_sprite (
    input  logic [7:0] col,
    input  logic [7:0] pos,
    input  logic [2:0] size_mode,
    input  logic [7:0] graphics,
    output logic       lit
);
    import rpg_pkg::*;

    sprite_shape_t shape;
    logic [7:0]    delta;
    logic [7:0]    offset;
    logic [7:0]    bit_idx;

    always_comb begin
        shape   = sprite_shape(size_mode);
        delta   = col - pos;
        offset  = delta & ~(8'hFF << shape.span_sh);
        bit_idx = offset >> shape.scale_sh;
        lit     = (col >= pos) && (delta < shape.extent) && (bit_idx < 8'd8)
                  && graphics[3'd7 - bit_idx[2:0]];
    end

endmodule

// ----- hw/rtl/raster_pixel_generator.sv -----
// Channel  | Dir | Ports                              | Contents
// input    | in  | s_tvalid s_tready s_tdata s_tuser  | tick or bus write
// result   | out | m_tvalid m_tready m_tdata m_tlast  | one pixel per tick
// config   | in  | cfg_we cfg_index cfg_data          | layer enables
//
// One word is taken every cycle unless a tick waits in the input register. A
// word's pixel is worked out in the input register and its result goes to the
// output register. Bus writes produce no result and never wait on the output
// side. Reset is synchronous on aresetn; all layers are enabled after it. A
// tick waits in the input register only while the output word stalls.
module raster_pixel_generator #(
    parameter int FRAME_LINES = 312
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [5:0] bus_address, [13:6] write_data, [15:14] zero
    input  logic [rpg_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] command
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] pixel_x, [16:8] pixel_y, [23:17] color_index, [24] cpu_active,
    // [25] vblank_active, [41:26] frame_count, [57:42] lines_latched,
    // [63:58] zero
    output logic [rpg_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic                          cfg_data
);
    import rpg_pkg::*;

    localparam logic [9:0] ROW_LIMIT = 10'(FRAME_LINES);

    // Input register.
    logic       in_valid_reg;
    logic       in_cmd_reg;
    logic [5:0] in_addr_reg;
    logic [7:0] in_data_reg;

    // Output register.
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_last_reg;

    // Configuration.
    logic show_pf_reg, show_p0_reg, show_p1_reg;

    // Video state.
    logic [7:0]  col_reg,        col_next;
    logic [8:0]  row_reg,        row_next;
    logic [15:0] line_cnt_reg,   line_cnt_next;
    logic [15:0] line_cap_reg,   line_cap_next;
    logic [15:0] frame_cnt_reg,  frame_cnt_next;
    logic        vblank_reg,     vblank_next;
    logic        wait_reg,       wait_next;
    logic [6:0]  col_bk_reg,     col_bk_next;
    logic [6:0]  col_pf_reg,     col_pf_next;
    logic [6:0]  col_p0_reg,     col_p0_next;
    logic [6:0]  col_p1_reg,     col_p1_next;
    logic [7:0]  pf0_reg,        pf0_next;
    logic [7:0]  pf1_reg,        pf1_next;
    logic [7:0]  pf2_reg,        pf2_next;
    logic        mirror_reg,     mirror_next;
    logic [2:0]  nusiz_reg [2];
    logic [2:0]  nusiz_next [2];
    logic [3:0]  hm_reg [2];
    logic [3:0]  hm_next [2];
    logic [7:0]  pos_reg [2];
    logic [7:0]  pos_next [2];
    logic [2:0]  size_reg [2];
    logic [2:0]  size_next [2];
    logic [7:0]  grp_reg [2];
    logic [7:0]  grp_next [2];

    logic       out_free;
    logic       in_fire;
    logic       is_tick;
    logic       visible;
    logic [7:0] vis_col;
    logic [19:0] pf_bits;
    logic [5:0] pf_cell;
    logic [4:0] pf_idx;
    logic       pf_lit;
    logic [1:0] sp_lit;
    logic [6:0] color;
    logic       at_line_end;
    logic [9:0] row_inc;
    logic [8:0] place_sum [2];

    assign out_free = ~out_valid_reg | m_tready;
    assign in_fire  = in_valid_reg & (in_cmd_reg | out_free);
    assign is_tick  = ~in_cmd_reg;
    assign s_tready = ~in_valid_reg | in_fire;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Pixel color.
    always_comb begin
        visible = col_reg >= BLANK_CLOCKS;
        vis_col = col_reg - BLANK_CLOCKS;
        // Playfield bit order: PF0 bits 4..7, PF1 bits 7..0, PF2 bits 0..7.
        pf_bits = {pf2_reg,
                   pf1_reg[0], pf1_reg[1], pf1_reg[2], pf1_reg[3],
                   pf1_reg[4], pf1_reg[5], pf1_reg[6], pf1_reg[7],
                   pf0_reg[7:4]};
        pf_cell = vis_col[7:2];
        if (pf_cell < 6'd20) begin
            pf_idx = pf_cell[4:0];
        end else if (mirror_reg) begin
            pf_idx = 5'(6'd39 - pf_cell);
        end else begin
            pf_idx = 5'(pf_cell - 6'd20);
        end
        pf_lit = pf_bits[pf_idx];

        color = col_bk_reg;
        if (visible) begin
            if (show_pf_reg && pf_lit) color = col_pf_reg;
            if (show_p0_reg && sp_lit[0]) color = col_p0_reg;
            if (show_p1_reg && sp_lit[1]) color = col_p1_reg;
        end
    end

    for (genvar p = 0; p < 2; p++) begin : g_player
        rpg_sprite u_sprite (
            .col       (vis_col),
            .pos       (pos_reg[p]),
            .size_mode (size_reg[p]),
            .graphics  (grp_reg[p]),
            .lit       (sp_lit[p])
        );
        // Reset position before the wrap: col + 160 - 68 + motion + 4.
        assign place_sum[p] = 9'(col_reg) + 9'd96 + 9'({~hm_reg[p][3], hm_reg[p][2:0]});
    end

    // Next state.
    always_comb begin
        col_next       = col_reg;
        row_next       = row_reg;
        line_cnt_next  = line_cnt_reg;
        line_cap_next  = line_cap_reg;
        frame_cnt_next = frame_cnt_reg;
        vblank_next    = vblank_reg;
        wait_next      = wait_reg;
        col_bk_next    = col_bk_reg;
        col_pf_next    = col_pf_reg;
        col_p0_next    = col_p0_reg;
        col_p1_next    = col_p1_reg;
        pf0_next       = pf0_reg;
        pf1_next       = pf1_reg;
        pf2_next       = pf2_reg;
        mirror_next    = mirror_reg;
        nusiz_next     = nusiz_reg;
        hm_next        = hm_reg;
        pos_next       = pos_reg;
        size_next      = size_reg;
        grp_next       = grp_reg;
        at_line_end    = col_reg == LAST_COLUMN;
        row_inc        = 10'(row_reg) + 10'd1;

        if (in_fire && is_tick) begin
            if (at_line_end) begin
                col_next = '0;
                row_next = (row_inc >= ROW_LIMIT) ? ROW_LIMIT[8:0] : row_inc[8:0];
                if (line_cnt_reg != 16'hFFFF) line_cnt_next = line_cnt_reg + 16'd1;
                wait_next = 1'b0;
            end else begin
                col_next = col_reg + 8'd1;
            end
        end else if (in_fire) begin
            unique case (in_addr_reg)
                ADDR_VSYNC: begin
                    if (in_data_reg[1]) begin
                        row_next       = '0;
                        frame_cnt_next = frame_cnt_reg + 16'd1;
                    end
                end
                ADDR_VBLANK: begin
                    if (in_data_reg != 8'd0) begin
                        line_cap_next = line_cnt_reg;
                        line_cnt_next = '0;
                    end
                    vblank_next = in_data_reg != 8'd0;
                end
                ADDR_WSYNC:  wait_next     = 1'b1;
                ADDR_NUSIZ0: nusiz_next[0] = in_data_reg[2:0];
                ADDR_NUSIZ1: nusiz_next[1] = in_data_reg[2:0];
                ADDR_COLUP0: col_p0_next   = in_data_reg[7:1];
                ADDR_COLUP1: col_p1_next   = in_data_reg[7:1];
                ADDR_COLUPF: col_pf_next   = in_data_reg[7:1];
                ADDR_COLUBK: col_bk_next   = in_data_reg[7:1];
                ADDR_CTRLPF: mirror_next   = in_data_reg[0];
                ADDR_PF0:    pf0_next      = in_data_reg;
                ADDR_PF1:    pf1_next      = in_data_reg;
                ADDR_PF2:    pf2_next      = in_data_reg;
                ADDR_RESP0, ADDR_RESP1: begin
                    for (int p = 0; p < 2; p++) begin
                        if (in_addr_reg[0] == p[0]) begin
                            if (place_sum[p] >= 9'd320) begin
                                pos_next[p] = 8'(place_sum[p] - 9'd320);
                            end else if (place_sum[p] >= VISIBLE_COLUMNS) begin
                                pos_next[p] = 8'(place_sum[p] - VISIBLE_COLUMNS);
                            end else begin
                                pos_next[p] = place_sum[p][7:0];
                            end
                            size_next[p] = nusiz_reg[p];
                        end
                    end
                end
                ADDR_GRP0: begin
                    grp_next[0]  = in_data_reg;
                    size_next[0] = nusiz_reg[0];
                end
                ADDR_GRP1: begin
                    grp_next[1]  = in_data_reg;
                    size_next[1] = nusiz_reg[1];
                end
                ADDR_HMP0:   hm_next[0] = in_data_reg[3:0];
                ADDR_HMP1:   hm_next[1] = in_data_reg[3:0];
                default: ;
            endcase
        end
    end

    // Handshake control and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            show_pf_reg   <= 1'b1;
            show_p0_reg   <= 1'b1;
            show_p1_reg   <= 1'b1;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;
            if (in_fire && is_tick) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_SHOW_PF: show_pf_reg <= cfg_data;
                    CFG_SHOW_P0: show_p0_reg <= cfg_data;
                    CFG_SHOW_P1: show_p1_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= s_tuser;
            in_addr_reg <= s_tdata[5:0];
            in_data_reg <= s_tdata[13:6];
        end
        if (in_fire && is_tick) begin
            out_data_reg <= {6'd0, line_cap_reg, frame_cnt_reg, vblank_reg, ~wait_reg,
                             color, row_reg, col_reg};
            out_last_reg <= at_line_end;
        end
    end

    // Video state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            line_cnt_reg  <= '0;
            line_cap_reg  <= '0;
            frame_cnt_reg <= '0;
            vblank_reg    <= 1'b0;
            wait_reg      <= 1'b0;
            col_bk_reg    <= '0;
            col_pf_reg    <= '0;
            col_p0_reg    <= '0;
            col_p1_reg    <= '0;
            pf0_reg       <= '0;
            pf1_reg       <= '0;
            pf2_reg       <= '0;
            mirror_reg    <= 1'b0;
            for (int p = 0; p < 2; p++) begin
                nusiz_reg[p] <= '0;
                hm_reg[p]    <= '0;
                pos_reg[p]   <= '0;
                size_reg[p]  <= '0;
                grp_reg[p]   <= '0;
            end
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            line_cnt_reg  <= line_cnt_next;
            line_cap_reg  <= line_cap_next;
            frame_cnt_reg <= frame_cnt_next;
            vblank_reg    <= vblank_next;
            wait_reg      <= wait_next;
            col_bk_reg    <= col_bk_next;
            col_pf_reg    <= col_pf_next;
            col_p0_reg    <= col_p0_next;
            col_p1_reg    <= col_p1_next;
            pf0_reg       <= pf0_next;
            pf1_reg       <= pf1_next;
            pf2_reg       <= pf2_next;
            mirror_reg    <= mirror_next;
            nusiz_reg     <= nusiz_next;
            hm_reg        <= hm_next;
            pos_reg       <= pos_next;
            size_reg      <= size_next;
            grp_reg       <= grp_next;
        end
    end

endmodule

// ----- hw/rtl/rpg_checker.sv -----
module rpg_checker #(
    parameter int FRAME_LINES = 312
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rpg_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import rpg_pkg::*;

    // The last word of a line is exactly the one at the last column.
    a_last_column: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[7:0] == LAST_COLUMN)))
        else $error("line end does not match the last column");

    a_column_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] < LINE_CLOCKS))
        else $error("pixel column out of range");

    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (10'(m_tdata[16:8]) <= 10'(FRAME_LINES)))
        else $error("scan line above the frame bound");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result word changed");

endmodule

bind raster_pixel_generator rpg_checker #(.FRAME_LINES(FRAME_LINES)) u_rpg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- bench/testbench.sv -----
module testbench;
    import rpg_pkg::*;

    localparam int ROW_LIMIT    = 192;
    localparam int DRAIN_CYCLES = 4;
    localparam int LONG_STALL   = 400;
    localparam int MAX_REPORTS  = 10;

    localparam bit [5:0] ADDR_UNMAPPED = 6'h3f;

    typedef struct packed {
        bit       cmd;
        bit [5:0] addr;
        bit [7:0] data;
    } bus_item_t;

    typedef struct packed {
        bit [7:0]  x;
        bit [8:0]  y;
        bit [6:0]  color;
        bit        cpu_active;
        bit        vblank;
        bit [15:0] frames;
        bit [15:0] lines;
        bit        line_end;
    } pixel_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_SHOW_PF;
    logic        cfg_data  = 1'b0;

    raster_pixel_generator #(.FRAME_LINES(ROW_LIMIT)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    bus_item_t pending_words[$];
    pixel_t    predicted_pixels[$];

    int sender_idle_pct = 21;
    int recv_idle_pct   = 75;
    bit long_stall_req  = 0;
    bit long_stall_done = 0;
    int stall_left      = 0;
    int mismatches      = 0;
    int pixels_checked  = 0;
    int writes_sent     = 0;

    // Shadow of the video state, updated as each word is accepted.
    bit [7:0]  scan_col;
    bit [8:0]  scan_row;
    bit [15:0] line_total, line_snapshot, frame_total;
    bit        vblank_on, cpu_held, mirror_on;
    bit        show_pf, show_p0, show_p1;
    bit [6:0]  palette [4];
    bit [7:0]  pf_byte [3];
    bit [2:0]  nusiz_now [2];
    bit [3:0]  hmove_nib [2];
    bit [7:0]  player_x [2];
    bit [2:0]  nusiz_drawn [2];
    bit [7:0]  player_gfx [2];

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("timeout with %0d words queued and %0d pixels outstanding",
                 pending_words.size(), predicted_pixels.size());
        $display("raster_pixel_generator verification failed");
        $finish;
    end

    task automatic clear_video_state();
        scan_col = 0; scan_row = 0; line_total = 0; line_snapshot = 0; frame_total = 0;
        vblank_on = 0; cpu_held = 0; mirror_on = 0;
        show_pf = 1; show_p0 = 1; show_p1 = 1;
        for (int i = 0; i < 4; i++) palette[i] = 0;
        for (int i = 0; i < 3; i++) pf_byte[i] = 0;
        for (int i = 0; i < 2; i++) begin
            nusiz_now[i] = 0; hmove_nib[i] = 0; player_x[i] = 0;
            nusiz_drawn[i] = 0; player_gfx[i] = 0;
        end
    endtask

    // Playfield bit order: PF0 high nibble ascending, PF1 descending, PF2 ascending.
    function automatic bit pf_cell(int i);
        if (i < 4) return pf_byte[0][4 + i];
        if (i < 12) return pf_byte[1][11 - i];
        return pf_byte[2][i - 12];
    endfunction

    function automatic bit playfield_on(int c);
        int i;
        i = c / 4;
        if (i < 20) return pf_cell(i);
        return mirror_on ? pf_cell(39 - i) : pf_cell(i - 20);
    endfunction

    function automatic bit player_on(int p, int c);
        int copies, scale, gap, d, span, o;
        case (nusiz_drawn[p])
            3'd0: begin copies = 1; scale = 1; gap = 0; end
            3'd1: begin copies = 2; scale = 1; gap = 1; end
            3'd2: begin copies = 2; scale = 1; gap = 3; end
            3'd3: begin copies = 3; scale = 1; gap = 1; end
            3'd4: begin copies = 2; scale = 1; gap = 7; end
            3'd5: begin copies = 1; scale = 2; gap = 0; end
            3'd6: begin copies = 3; scale = 1; gap = 3; end
            default: begin copies = 1; scale = 4; gap = 0; end
        endcase
        if (c < int'(player_x[p])) return 0;
        d = c - int'(player_x[p]);
        span = 8 * scale + 8 * gap;
        if (d >= span * copies) return 0;
        o = d % span;
        if (o >= 8 * scale) return 0;
        return player_gfx[p][7 - o / scale];
    endfunction

    task automatic reposition_player(int p);
        int shift;
        shift = (hmove_nib[p] < 8) ? int'(hmove_nib[p]) + 8 : int'(hmove_nib[p]) - 8;
        player_x[p] = 8'((int'(scan_col) + 160 - 68 + shift + 4) % 160);
        nusiz_drawn[p] = nusiz_now[p];
    endtask

    task automatic apply_bus_write(bit [5:0] a, bit [7:0] v);
        case (a)
            ADDR_VSYNC: if (v[1]) begin
                scan_row = 0;
                frame_total = frame_total + 16'd1;
            end
            ADDR_VBLANK: begin
                if (v != 0) begin
                    line_snapshot = line_total;
                    line_total = 0;
                end
                vblank_on = (v != 0);
            end
            ADDR_WSYNC:  cpu_held = 1;
            ADDR_NUSIZ0: nusiz_now[0] = v[2:0];
            ADDR_NUSIZ1: nusiz_now[1] = v[2:0];
            ADDR_COLUP0: palette[2] = v[7:1];
            ADDR_COLUP1: palette[3] = v[7:1];
            ADDR_COLUPF: palette[1] = v[7:1];
            ADDR_COLUBK: palette[0] = v[7:1];
            ADDR_CTRLPF: mirror_on = v[0];
            ADDR_PF0:    pf_byte[0] = v;
            ADDR_PF1:    pf_byte[1] = v;
            ADDR_PF2:    pf_byte[2] = v;
            ADDR_RESP0:  reposition_player(0);
            ADDR_RESP1:  reposition_player(1);
            ADDR_GRP0: begin
                player_gfx[0] = v;
                nusiz_drawn[0] = nusiz_now[0];
            end
            ADDR_GRP1: begin
                player_gfx[1] = v;
                nusiz_drawn[1] = nusiz_now[1];
            end
            ADDR_HMP0:   hmove_nib[0] = v[3:0];
            ADDR_HMP1:   hmove_nib[1] = v[3:0];
            default: ;
        endcase
    endtask

    task automatic advance_raster(bus_item_t w);
        pixel_t px;
        int c;
        if (w.cmd) begin
            apply_bus_write(w.addr, w.data);
            return;
        end
        px.color = palette[0];
        if (scan_col >= BLANK_CLOCKS) begin
            c = int'(scan_col) - int'(BLANK_CLOCKS);
            if (show_pf && playfield_on(c)) px.color = palette[1];
            if (show_p0 && player_on(0, c)) px.color = palette[2];
            if (show_p1 && player_on(1, c)) px.color = palette[3];
        end
        px.x = scan_col;
        px.y = scan_row;
        px.cpu_active = !cpu_held;
        px.vblank = vblank_on;
        px.frames = frame_total;
        px.lines = line_snapshot;
        px.line_end = 0;
        scan_col = scan_col + 8'd1;
        if (scan_col >= LINE_CLOCKS) begin
            px.line_end = 1;
            scan_col = 0;
            scan_row = scan_row + 9'd1;
            if (scan_row >= ROW_LIMIT) scan_row = 9'(ROW_LIMIT);
            if (line_total != 16'hffff) line_total = line_total + 16'd1;
            cpu_held = 0;
        end
        predicted_pixels.push_back(px);
    endtask

    task automatic compare_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("pixel %0d: %s expected %0d, got %0d", pixels_checked, name, want, got);
        end
    endtask

    // Driver: presents the head of the word queue and holds it until taken.
    always @(posedge aclk) begin
        bit offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_raster(pending_words[0]);
                if (pending_words[0].cmd) writes_sent++;
                void'(pending_words.pop_front());
            end
            offer = s_tvalid && !s_tready;
            if (!offer)
                offer = (pending_words.size() != 0) && ($urandom_range(99) >= sender_idle_pct);
            if (offer) begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_words[0].cmd;
                s_tdata  <= {2'b00, pending_words[0].data, pending_words[0].addr};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each pixel word and throttles the output side.
    always @(posedge aclk) begin
        pixel_t want;
        bit ready_next;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (predicted_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected pixel word %h", m_tdata);
                end else begin
                    want = predicted_pixels.pop_front();
                    compare_field("pixel_x", want.x, m_tdata[7:0]);
                    compare_field("pixel_y", want.y, m_tdata[16:8]);
                    compare_field("color_index", want.color, m_tdata[23:17]);
                    compare_field("cpu_active", want.cpu_active, m_tdata[24]);
                    compare_field("vblank_active", want.vblank, m_tdata[25]);
                    compare_field("frame_count", want.frames, m_tdata[41:26]);
                    compare_field("lines_latched", want.lines, m_tdata[57:42]);
                    compare_field("padding", 0, m_tdata[63:58]);
                    compare_field("line_end", want.line_end, m_tlast);
                end
                pixels_checked++;
            end
            if (stall_left != 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if (long_stall_req && !long_stall_done) begin
                stall_left = LONG_STALL;
                long_stall_done = 1;
                ready_next = 1'b0;
            end else begin
                ready_next = ($urandom_range(99) >= recv_idle_pct);
            end
            m_tready <= ready_next;
        end
    end

    task automatic queue_write(bit [5:0] a, bit [7:0] v);
        bus_item_t w;
        w.cmd = 1; w.addr = a; w.data = v;
        pending_words.push_back(w);
    endtask

    task automatic queue_ticks(int n);
        bus_item_t w;
        w.cmd = 0;
        repeat (n) begin
            w.addr = 6'($urandom_range(63));
            w.data = 8'($urandom_range(255));
            pending_words.push_back(w);
        end
    endtask

    function automatic bit [5:0] mapped_register(int k);
        case (k)
            0:  return ADDR_VSYNC;
            1:  return ADDR_VBLANK;
            2:  return ADDR_WSYNC;
            3:  return ADDR_NUSIZ0;
            4:  return ADDR_NUSIZ1;
            5:  return ADDR_COLUP0;
            6:  return ADDR_COLUP1;
            7:  return ADDR_COLUPF;
            8:  return ADDR_COLUBK;
            9:  return ADDR_CTRLPF;
            10: return ADDR_PF0;
            11: return ADDR_PF1;
            12: return ADDR_PF2;
            13: return ADDR_RESP0;
            14: return ADDR_RESP1;
            15: return ADDR_GRP0;
            16: return ADDR_GRP1;
            17: return ADDR_HMP0;
            default: return ADDR_HMP1;
        endcase
    endfunction

    // A burst of register writes followed by a run of ticks; the occasional
    // write to a random address is noise that the block mostly ignores.
    task automatic queue_scene(bit allow_vsync, output int counted, output int ticks);
        bit [5:0] a;
        bit [7:0] v;
        counted = 0;
        repeat ($urandom_range(0, 5)) begin
            v = 8'($urandom_range(255));
            if ($urandom_range(9) == 0) begin
                a = 6'($urandom_range(63));
                if (!allow_vsync && a == ADDR_VSYNC) a = ADDR_UNMAPPED;
                queue_write(a, v);
            end else begin
                a = mapped_register($urandom_range(allow_vsync ? 0 : 1, 18));
                if (a == ADDR_VBLANK && $urandom_range(2) == 0) v = 0;
                queue_write(a, v);
                counted++;
            end
        end
        ticks = ($urandom_range(3) == 0) ? $urandom_range(1, 16) : $urandom_range(20, 160);
        queue_ticks(ticks);
        counted += ticks;
    endtask

    task automatic settle();
        wait (pending_words.size() == 0 && predicted_pixels.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_layer_enable(bit [1:0] idx, bit v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_SHOW_PF: show_pf = v;
            CFG_SHOW_P0: show_p0 = v;
            CFG_SHOW_P1: show_p1 = v;
            default: ;
        endcase
    endtask

    task automatic set_layers(bit pf, bit p0, bit p1);
        write_layer_enable(CFG_SHOW_PF, pf);
        write_layer_enable(CFG_SHOW_P0, p0);
        write_layer_enable(CFG_SHOW_P1, p1);
        @(negedge aclk);
    endtask

    task automatic run_phase(int tx_idle, int rx_idle, int budget, bit with_pause);
        int done, n, t;
        bit paused;
        done = 0;
        paused = 0;
        sender_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        while (done < budget) begin
            queue_scene(1, n, t);
            done += n;
            // Let the input side go quiet until every pixel so far has come back.
            if (with_pause && !paused && done >= budget / 2) begin
                wait (pending_words.size() == 0 && predicted_pixels.size() == 0);
                @(negedge aclk);
                paused = 1;
            end
        end
        settle();
    endtask

    initial begin
        clear_video_state();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed line with layer defaults: first pixel after reset, extreme
        // register values, one player at the right edge, flags and an
        // unmapped address.
        queue_ticks(1);
        queue_write(ADDR_COLUBK, 8'h02);
        queue_write(ADDR_COLUPF, 8'hfe);
        queue_write(ADDR_COLUP0, 8'h54);
        queue_write(ADDR_COLUP1, 8'hab);
        queue_write(ADDR_PF0, 8'hf0);
        queue_write(ADDR_PF1, 8'h81);
        queue_write(ADDR_PF2, 8'h80);
        queue_write(ADDR_CTRLPF, 8'hff);
        queue_write(ADDR_NUSIZ0, 8'hff);
        queue_write(ADDR_NUSIZ1, 8'h03);
        queue_write(ADDR_HMP0, 8'hf8);
        queue_write(ADDR_HMP1, 8'h07);
        queue_write(ADDR_GRP0, 8'hff);
        queue_write(ADDR_GRP1, 8'h81);
        queue_write(ADDR_VBLANK, 8'hff);
        queue_write(ADDR_UNMAPPED, 8'hff);
        queue_ticks(149);
        queue_write(ADDR_RESP0, 8'h00);
        queue_ticks(50);
        queue_write(ADDR_RESP1, 8'h00);
        queue_write(ADDR_WSYNC, 8'h00);
        queue_ticks(28 + 228);
        queue_write(ADDR_VBLANK, 8'h00);
        queue_write(ADDR_VSYNC, 8'hfd);
        queue_write(ADDR_VSYNC, 8'h02);
        queue_ticks(40);
        settle();

        set_layers(1, 0, 1);
        run_phase(21, 75, 260, 1);

        set_layers(0, 1, 0);
        run_phase(75, 21, 260, 0);

        set_layers(0, 0, 0);
        long_stall_req = 1;
        run_phase(0, 0, 260, 0);
        long_stall_req = 0;

        if (predicted_pixels.size() != 0) begin
            mismatches += predicted_pixels.size();
            $display("%0d pixels never arrived", predicted_pixels.size());
        end
        $display("Checked %0d pixels and %0d bus writes across four layer settings,",
                 pixels_checked, writes_sent);
        $display("with throttled and free-running phases, an input pause and a long output stall.");
        if (mismatches == 0) begin
            $display("raster_pixel_generator verification clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("raster_pixel_generator verification failed");
        end
        $finish;
    end

endmodule
